// File: hw/rtl/sbls_pkg.sv
// ----------------------------------------------------------------------------
// sbls_pkg: shared types and constants for the block sieve
// Transaction payloads, function codes, internal command format and queue
// sizing used by the front end, the command queue and the sieve engine.
// ----------------------------------------------------------------------------
`default_nettype none

package sbls_pkg;

  // Function codes carried in the func field of an input transaction.
  localparam logic [1:0] FN_CLEAR  = 2'd0;
  localparam logic [1:0] FN_PRIME  = 2'd1;
  localparam logic [1:0] FN_BUCKET = 2'd2;
  localparam logic [1:0] FN_READ   = 2'd3;

  // Depth of the command queue between the front end and the engine.
  // It must be a power of two.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] prime;
    logic [15:0] root_low;
    logic [15:0] root_high;
    logic [7:0]  logp;
    logic [14:0] location;
  } in_item_t;

  typedef struct packed {
    logic [15:0] next_root_low;
    logic [15:0] next_root_high;
    logic [7:0]  read_value;
  } out_item_t;

  // Work classes decided by the front end.
  typedef enum logic [2:0] {
    OP_CLEAR,
    OP_PRIME,
    OP_PASS,
    OP_BUCKET,
    OP_READ,
    OP_READ_ZERO
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] prime;
    logic [15:0] root_low;
    logic [15:0] root_high;
    logic [7:0]  logp;
    logic [14:0] location;
  } cmd_t;

endpackage

`default_nettype wire

// File: hw/rtl/sbls_ram.sv
// ----------------------------------------------------------------------------
// sbls_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sbls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32768
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hw/rtl/sbls_front.sv
// ----------------------------------------------------------------------------
// sbls_front: input decode and classification
// Turns each input transaction into an engine command, settles the cases that
// need no sieve access and drops bucket hits that fall outside the block.
// ----------------------------------------------------------------------------
`default_nettype none

module sbls_front import sbls_pkg::*; #(
  parameter int BLOCK_SIZE = 32768
) (
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  input  wire logic     queue_full,
  output logic          push,
  output cmd_t          push_cmd
);

  logic accept;
  logic loc_in_block;
  logic roots_swapped;

  assign in_stall      = queue_full;
  assign accept        = in_valid && !queue_full;
  assign loc_in_block  = ({1'b0, in_data.location} < 16'(BLOCK_SIZE));
  assign roots_swapped = (in_data.root_low > in_data.root_high);

  always_comb begin
    push_cmd.prime     = in_data.prime;
    push_cmd.root_low  = in_data.root_low;
    push_cmd.root_high = in_data.root_high;
    push_cmd.logp      = in_data.logp;
    push_cmd.location  = in_data.location;
    push_cmd.op        = OP_CLEAR;
    push               = accept;
    unique case (in_data.func)
      FN_CLEAR: begin
        push_cmd.op = OP_CLEAR;
      end
      FN_PRIME: begin
        if (in_data.prime == 16'd0) begin
          // A zero prime touches nothing; the engine only returns the
          // roots, which are ordered here.
          push_cmd.op = OP_PASS;
          if (roots_swapped) begin
            push_cmd.root_low  = in_data.root_high;
            push_cmd.root_high = in_data.root_low;
          end
        end else begin
          push_cmd.op = OP_PRIME;
        end
      end
      FN_BUCKET: begin
        push_cmd.op = OP_BUCKET;
        push        = accept && loc_in_block;
      end
      FN_READ: begin
        push_cmd.op = loc_in_block ? OP_READ : OP_READ_ZERO;
      end
      default: begin
        push_cmd.op = OP_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/sbls_queue.sv
// ----------------------------------------------------------------------------
// sbls_queue: command queue
// Small register FIFO between the front end and the sieve engine.
// ----------------------------------------------------------------------------
`default_nettype none

module sbls_queue import sbls_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      cmd_valid,
  output cmd_t      pop_cmd
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full      = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign cmd_valid = (count != '0);
  assign pop_cmd   = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/sbls_engine.sv
// ----------------------------------------------------------------------------
// sbls_engine: sieve engine
// Carries out queued commands against the sieve RAM: block clear sweep,
// prime walks with read-modify-write per hit, bucket hits and entry reads.
// Holds the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sbls_engine import sbls_pkg::*; #(
  parameter int BLOCK_SIZE = 32768
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] init_value,
  input  wire logic       cmd_valid,
  input  wire cmd_t       cmd,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_item_t       out_data
);

  localparam int ADDR_W = $clog2(BLOCK_SIZE);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_WALK,
    S_HIT,
    S_RD_ADDR,
    S_RD_DATA,
    S_RESULT
  } state_t;

  state_t            state;
  logic              is_bucket;
  logic              second;
  logic [16:0]       pos;
  logic [15:0]       prime;
  logic [7:0]        logp;
  logic [15:0]       root_next;
  logic [15:0]       first_next;
  logic [ADDR_W-1:0] clr_cnt;
  out_item_t         res;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic [7:0]        ram_rdata;
  logic              pos_in_block;
  logic [15:0]       pos_next_root;

  assign pop           = (state == S_IDLE) && cmd_valid;
  assign pos_in_block  = (pos < 17'(BLOCK_SIZE));
  assign pos_next_root = 16'(pos - 17'(BLOCK_SIZE));

  assign ram_we    = (state == S_CLEAR) || (state == S_HIT);
  assign ram_waddr = (state == S_CLEAR) ? clr_cnt : pos[ADDR_W-1:0];
  assign ram_wdata = (state == S_CLEAR) ? init_value : (ram_rdata - logp);

  sbls_ram #(
    .WIDTH (8),
    .DEPTH (BLOCK_SIZE)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (pos[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      is_bucket <= 1'b0;
      second    <= 1'b0;
    end else begin
      // In S_RESULT the output register is reloaded below instead.
      if (out_valid && !out_stall && (state != S_RESULT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            logp <= cmd.logp;
            unique case (cmd.op)
              OP_CLEAR: begin
                clr_cnt <= '0;
                state   <= S_CLEAR;
              end
              OP_PRIME: begin
                pos       <= {1'b0, cmd.root_low};
                root_next <= cmd.root_high;
                prime     <= cmd.prime;
                second    <= 1'b0;
                is_bucket <= 1'b0;
                state     <= S_WALK;
              end
              OP_PASS: begin
                res   <= '{next_root_low: cmd.root_low, next_root_high: cmd.root_high,
                           read_value: 8'd0};
                state <= S_RESULT;
              end
              OP_BUCKET: begin
                pos       <= {2'b00, cmd.location};
                is_bucket <= 1'b1;
                state     <= S_WALK;
              end
              OP_READ: begin
                pos   <= {2'b00, cmd.location};
                state <= S_RD_ADDR;
              end
              OP_READ_ZERO: begin
                res   <= '0;
                state <= S_RESULT;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == ADDR_W'(BLOCK_SIZE - 1)) begin
            state <= S_IDLE;
          end
        end
        S_WALK: begin
          if (pos_in_block) begin
            state <= S_HIT;
          end else if (!second) begin
            first_next <= pos_next_root;
            pos        <= {1'b0, root_next};
            second     <= 1'b1;
          end else begin
            if (first_next > pos_next_root) begin
              res <= '{next_root_low: pos_next_root, next_root_high: first_next,
                       read_value: 8'd0};
            end else begin
              res <= '{next_root_low: first_next, next_root_high: pos_next_root,
                       read_value: 8'd0};
            end
            state <= S_RESULT;
          end
        end
        S_HIT: begin
          pos   <= pos + {1'b0, prime};
          state <= is_bucket ? S_IDLE : S_WALK;
        end
        S_RD_ADDR: begin
          state <= S_RD_DATA;
        end
        S_RD_DATA: begin
          res   <= '{next_root_low: 16'd0, next_root_high: 16'd0, read_value: ram_rdata};
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (!out_valid || !out_stall) begin
            out_data  <= res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/sieve_block_log_subtract_top.sv
// ----------------------------------------------------------------------------
// sieve_block_log_subtract_top: block sieve with log subtraction
// The block holds a byte sieve of BLOCK_SIZE entries in one RAM. A clear
// transaction fills it with init_value, a prime transaction subtracts logp at
// every root + k*prime below BLOCK_SIZE for both roots and returns the sorted
// next-block roots, a bucket-hit transaction subtracts logp at one location
// and a read transaction returns one entry. A front end decodes transactions
// into a four-entry command queue, and a sieve engine drains it, so input is
// taken while the engine works and while a result waits in the output
// register. Every hit is a read-modify-write through the single read and
// single write port of the sieve RAM; a zero prime or a read outside the
// block needs no RAM access. A stalled output holds the engine once the
// output register is full. Bucket hits outside the block are dropped at
// the front end and cost nothing. The sieve contents are undefined after
// reset until a clear transaction runs; there is no clearing pass. init_value
// resets to zero and may be written whenever the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module sieve_block_log_subtract_top import sbls_pkg::*; #(
  parameter int BLOCK_SIZE = 32768
) (
  input  wire logic       clk,
  input  wire logic       rst,
  // Input transactions.
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_item_t   in_data,
  // Result transactions.
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_item_t       out_data,
  // Configuration write channel for init_value.
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data
);

  logic [7:0] init_value;
  logic       queue_full;
  logic       push;
  cmd_t       push_cmd;
  logic       pop;
  logic       cmd_valid;
  cmd_t       pop_cmd;

  // The one configuration register is always ready to be written.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      init_value <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      init_value <= cfg_data;
    end
  end

  // The front end classifies each transaction as it is accepted.
  sbls_front #(
    .BLOCK_SIZE (BLOCK_SIZE)
  ) u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .queue_full (queue_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  // The queue decouples the input side from the engine.
  sbls_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (queue_full),
    .pop       (pop),
    .cmd_valid (cmd_valid),
    .pop_cmd   (pop_cmd)
  );

  // The engine owns the sieve RAM and the output register.
  sbls_engine #(
    .BLOCK_SIZE (BLOCK_SIZE)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .init_value (init_value),
    .cmd_valid  (cmd_valid),
    .cmd        (pop_cmd),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

// File: hw/rtl/sbls_checker.sv
// ----------------------------------------------------------------------------
// sbls_checker: port-level checks for the block sieve
// Watches the top-level ports and flags results that were never asked for,
// unordered roots, mixed result kinds and unstable stalled results.
// ----------------------------------------------------------------------------
`default_nettype none

module sbls_checker import sbls_pkg::*; (
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire in_item_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);

  // Number of accepted prime and read transactions whose result has not
  // yet been taken.
  logic [3:0] pending;
  logic       in_take;
  logic       out_take;
  logic       wants_result;

  assign in_take      = in_valid && !in_stall;
  assign out_take     = out_valid && !out_stall;
  assign wants_result = (in_data.func == FN_PRIME) || (in_data.func == FN_READ);

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 4'(in_take && wants_result) - 4'(out_take);
    end
  end

  a_no_unrequested_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pending != 4'd0))
    else $error("result shown with no outstanding prime or read transaction");

  a_roots_sorted: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.next_root_low <= out_data.next_root_high))
    else $error("next roots are not in ascending order");

  a_result_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.read_value == 8'd0) ||
                   ((out_data.next_root_low == 16'd0) && (out_data.next_root_high == 16'd0))))
    else $error("result carries both root and read data");

  a_stalled_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed or was withdrawn");

endmodule

bind sieve_block_log_subtract_top sbls_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
